/* src/ir2d_pkg.sv */
// Shared types, constants and helpers for the integer to radix digit converter.
`default_nettype none

package ir2d_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int RADIX_W        = 6;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 7;
    localparam int OUT_DATA_W     = 8;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [RADIX_W-1:0]    RADIX_RESET   = 6'd10;
    localparam logic [RADIX_W-1:0]    RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0]    RADIX_MAX     = 6'd36;
    localparam logic [DIGIT_W-1:0]    DEC_DIGITS    = 6'd10;
    localparam logic [CHAR_W-1:0]     CHAR_ZERO     = 7'h30;
    localparam logic [CHAR_W-1:0]     CHAR_A        = 7'h41;
    localparam logic [CHAR_W-1:0]     CHAR_NONE     = 7'h00;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIX_ADDR = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ALIGN,
        ST_EMIT,
        ST_ZERO,
        ST_BAD
    } state_t;

    typedef enum logic [1:0] {
        OUT_DIGIT,
        OUT_ZERO,
        OUT_BAD
    } out_sel_t;

    typedef struct packed {
        logic     load;
        logic     conv;
        logic     align;
        logic     emit;
        out_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic in_zero;
        logic radix_ok;
        logic conv_done;
        logic align_done;
        logic last;
    } stat_t;

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DEC_DIGITS)
            ch = CHAR_ZERO + CHAR_W'(d);
        else
            ch = CHAR_A + CHAR_W'(d - DEC_DIGITS);
        return ch;
    endfunction

endpackage

`default_nettype wire

/* src/ir2d_ctrl.sv */
// Digit converter sequencer: convert, align, emit; or zero/bad result.
`default_nettype none

module ir2d_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire ir2d_pkg::stat_t stat,
    output ir2d_pkg::cmd_t      cmd
);
    import ir2d_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    priority if (stat.in_zero)
                        state_next = ST_ZERO;
                    else if (!stat.radix_ok)
                        state_next = ST_BAD;
                    else
                        state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (stat.conv_done)
                    state_next = ST_ALIGN;
            end
            ST_ALIGN:
            begin
                if (stat.align_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_tready && stat.last)
                    state_next = ST_IDLE;
            end
            ST_ZERO, ST_BAD:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        cmd.load  = 1'b0;
        cmd.conv  = 1'b0;
        cmd.align = 1'b0;
        cmd.emit  = 1'b0;
        cmd.sel   = OUT_DIGIT;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid && !stat.in_zero && stat.radix_ok;
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
            end
            ST_ALIGN:
            begin
                cmd.align = !stat.align_done;
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                cmd.emit = m_tready;
            end
            ST_ZERO:
            begin
                m_tvalid = 1'b1;
                cmd.sel  = OUT_ZERO;
            end
            ST_BAD:
            begin
                m_tvalid = 1'b1;
                cmd.sel  = OUT_BAD;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/ir2d_dpath.sv */
// Datapath: row of base-N digit cells fed one value bit per cycle, MSB first.
`default_nettype none

module ir2d_dpath #(
    parameter int VALUE_BITS = ir2d_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [VALUE_BITS-1:0]         value,
    input  wire logic [ir2d_pkg::RADIX_W-1:0]  radix,
    input  wire ir2d_pkg::cmd_t                cmd,
    output ir2d_pkg::stat_t                    stat,
    output logic [ir2d_pkg::CHAR_W-1:0]        digit_char,
    output logic                               last_digit,
    output logic                               status
);
    import ir2d_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam logic [CW-1:0] FULL = CW'(VALUE_BITS);
    localparam logic [CW-1:0] ONE  = CW'(1);

    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [CW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         lvl_reg, lvl_next;
    logic [DIGIT_W-1:0]    digit_reg [VALUE_BITS];
    logic [DIGIT_W-1:0]    digit_next [VALUE_BITS];

    logic [DIGIT_W:0]      dbl [VALUE_BITS];
    logic [DIGIT_W:0]      radix_x;
    logic [VALUE_BITS-1:0] gen, prop;
    logic [VALUE_BITS:0]   sum, carry;

    // Each cell doubles and adds the carry from below; carry out when >= radix.
    // Generate/propagate per cell turns the chain into one wide add.
    always_comb
    begin
        radix_x = {1'b0, radix};
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            dbl[i]  = {digit_reg[i], 1'b0};
            gen[i]  = (dbl[i] >= radix_x);
            prop[i] = ((dbl[i] | (DIGIT_W+1)'(1)) == radix_x);
        end
        sum   = {1'b0, gen | prop} + {1'b0, gen}
              + (VALUE_BITS+1)'(val_reg[VALUE_BITS-1]);
        carry = sum ^ {1'b0, gen | prop} ^ {1'b0, gen};
    end

    always_comb
    begin
        val_next     = val_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        lvl_next     = lvl_reg;
        for (int i = 0; i < VALUE_BITS; i++)
            digit_next[i] = digit_reg[i];

        priority if (cmd.load)
        begin
            val_next     = value;
            bit_cnt_next = FULL;
            count_next   = '0;
            lvl_next     = '0;
            for (int i = 0; i < VALUE_BITS; i++)
                digit_next[i] = '0;
        end
        else if (cmd.conv)
        begin
            val_next     = val_reg << 1;
            bit_cnt_next = bit_cnt_reg - ONE;
            // a new top digit appears exactly when a carry reaches the first empty cell
            count_next   = count_reg + CW'(carry[count_reg]);
            lvl_next     = count_next;
            for (int i = 0; i < VALUE_BITS; i++)
            begin
                if (carry[i+1])
                    digit_next[i] = DIGIT_W'((dbl[i] | (DIGIT_W+1)'(carry[i])) - radix_x);
                else
                    digit_next[i] = DIGIT_W'(dbl[i] | (DIGIT_W+1)'(carry[i]));
            end
        end
        else if (cmd.align || cmd.emit)
        begin
            // shift toward the top cell; the top cell is the next digit out
            for (int i = VALUE_BITS - 1; i > 0; i--)
                digit_next[i] = digit_reg[i-1];
            digit_next[0] = '0;
            if (cmd.align)
                lvl_next = lvl_reg + ONE;
            else
                count_next = count_reg - ONE;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            count_reg   <= '0;
            lvl_reg     <= '0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            count_reg   <= count_next;
            lvl_reg     <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        for (int i = 0; i < VALUE_BITS; i++)
            digit_reg[i] <= digit_next[i];
    end

    always_comb
    begin
        stat.in_zero    = (value == '0);
        stat.radix_ok   = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
        stat.conv_done  = (bit_cnt_reg == ONE);
        stat.align_done = (lvl_reg == FULL);
        stat.last       = (count_reg == ONE);
    end

    always_comb
    begin
        unique case (cmd.sel)
            OUT_DIGIT:
            begin
                digit_char = ascii_of(digit_reg[VALUE_BITS-1]);
                last_digit = stat.last;
                status     = 1'b0;
            end
            OUT_ZERO:
            begin
                digit_char = CHAR_ZERO;
                last_digit = 1'b1;
                status     = 1'b0;
            end
            default:
            begin
                digit_char = CHAR_NONE;
                last_digit = 1'b1;
                status     = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/integer_to_radix_digits_unit.sv */
// One item in flight: each value goes through VALUE_BITS bit-shift steps through
// the digit cells, then alignment, then emission of one digit per cycle while
// m_tready is high; zero or a bad radix skips these steps and answers with a
// single result item.
// Reset (rst_n, async, active low): controller idle, radix = 10.
`default_nettype none

module integer_to_radix_digits_unit #(
    parameter int VALUE_BITS = ir2d_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ir2d_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [ir2d_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [ir2d_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,  // value
    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ir2d_pkg::OUT_DATA_W-1:0]        m_tdata,  // digit_char
    output logic                                   m_tlast,  // last_digit
    output logic                                   m_tuser   // status
);
    import ir2d_pkg::*;

    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [CHAR_W-1:0]  digit_char;
    cmd_t               cmd;
    stat_t              stat;

    assign pready = 1'b1;

    always_comb
    begin
        radix_next = radix_reg;
        if (psel && penable && pwrite && (paddr == REG_RADIX_ADDR))
            radix_next = pwdata[RADIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    always_comb
    begin
        if (paddr == REG_RADIX_ADDR)
            prdata = {{(CFG_DATA_W-RADIX_W){1'b0}}, radix_reg};
        else
            prdata = '0;
    end

    ir2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ir2d_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (s_tdata[VALUE_BITS-1:0]),
        .radix      (radix_reg),
        .cmd        (cmd),
        .stat       (stat),
        .digit_char (digit_char),
        .last_digit (m_tlast),
        .status     (m_tuser)
    );

    assign m_tdata = {{(OUT_DATA_W-CHAR_W){1'b0}}, digit_char};

`ifndef SYNTHESIS
    // one item in flight: never accepting while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while result pending");

    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("bad radix result malformed");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tdata[VALUE_BITS-1:0] == '0)) |=>
        (m_tvalid && m_tlast && !m_tuser && (m_tdata[CHAR_W-1:0] == CHAR_ZERO)))
        else $error("zero value did not yield a single zero digit");
`endif

endmodule

`default_nettype wire

/* dv/ir2d_digit_checker.sv */
// Checker for the radix digit converter: snoops config and streams, predicts digits, compares.
module ir2d_digit_checker #(
    parameter int VALUE_BITS = ir2d_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ir2d_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [ir2d_pkg::CFG_DATA_W-1:0]   pwdata,
    input  wire logic                              pready,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,  // value
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [ir2d_pkg::OUT_DATA_W-1:0]   m_tdata,  // digit_char
    input  wire logic                              m_tlast,  // last_digit
    input  wire logic                              m_tuser,  // status
    output int                                     errors,
    output int                                     pending
);
    import ir2d_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } digit_item_t;

    digit_item_t       digit_q[$];
    logic [RADIX_W-1:0] radix_cur;
    int                err_cnt = 0;

    assign errors = err_cnt;

    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
        if (d < 10)
            return CHAR_ZERO + CHAR_W'(d);
        return CHAR_A + CHAR_W'(d - 10);
    endfunction

    // Repeated division, remainders kept low digit first, pushed high digit first.
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] quo;
        logic [DIGIT_W-1:0]    rems [VALUE_BITS];
        int                    n;
        digit_item_t           d;
        if (v == '0) begin
            d = '{ch: CHAR_ZERO, last: 1'b1, bad: 1'b0};
            digit_q.push_back(d);
        end else if (radix_cur < RADIX_MIN || radix_cur > RADIX_MAX) begin
            d = '{ch: CHAR_NONE, last: 1'b1, bad: 1'b1};
            digit_q.push_back(d);
        end else begin
            quo = v;
            n = 0;
            while (quo != '0 && n < VALUE_BITS) begin
                rems[n] = DIGIT_W'(quo % VALUE_BITS'(radix_cur));
                quo = quo / VALUE_BITS'(radix_cur);
                n++;
            end
            for (int k = n - 1; k >= 0; k--) begin
                d = '{ch: char_of(rems[k]), last: (k == 0), bad: 1'b0};
                digit_q.push_back(d);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        digit_item_t want;
        if (!rst_n) begin
            radix_cur <= RADIX_RESET;
            digit_q.delete();
            pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (digit_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected digit item: char %h last %b status %b",
                                 m_tdata[CHAR_W-1:0], m_tlast, m_tuser);
                end else begin
                    want = digit_q.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.ch || m_tlast !== want.last ||
                        m_tuser !== want.bad) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("digit mismatch: expected char %h last %b status %b, got char %h last %b status %b",
                                     want.ch, want.last, want.bad,
                                     m_tdata[CHAR_W-1:0], m_tlast, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_digits(s_tdata[VALUE_BITS-1:0]);
            if (psel && penable && pwrite && pready && paddr == REG_RADIX_ADDR)
                radix_cur <= pwdata[RADIX_W-1:0];
            pending <= digit_q.size();
        end
    end

endmodule

/* dv/tb_integer_to_radix_digits_unit.sv */
// Top of the radix digit converter testbench: clock, reset, stimulus and verdict.
module tb_integer_to_radix_digits_unit;
    import ir2d_pkg::*;

    localparam int VB      = VALUE_BITS_DEF;
    localparam int TDATA_W = ((VB + 7) / 8) * 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata = '0;   // value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // digit_char
    logic                  m_tlast;        // last_digit
    logic                  m_tuser;        // status

    int   errors;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_active = 1'b0;
    event hold_kick;

    integer_to_radix_digits_unit #(.VALUE_BITS(VB)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    ir2d_digit_checker #(.VALUE_BITS(VB)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial
    begin
        forever
        begin
            @(hold_kick);
            hold_active <= 1'b1;
            repeat (400) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_integer_to_radix_digits_unit: errors");
        $finish;
    end

    task automatic send_value(input logic [VB-1:0] v);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(v);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Wait until every digit is out, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_RADIX_ADDR;
        pwdata  <= ($urandom & ~32'h3F) | CFG_DATA_W'(r);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [VB-1:0]      v;
        logic [RADIX_W-1:0] r;
        int                 pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 28;
        rx_idle_pct = 78;

        // reset radix is decimal
        send_value('0);
        send_value(VB'(1));
        send_value(VB'(9));
        send_value(VB'(10));
        send_value('1);
        send_value(VB'(1) << (VB - 1));
        drain();
        write_radix(RADIX_MIN);
        send_value(VB'(1));
        send_value('1);
        send_value(VB'(2));
        send_value(VB'(1) << (VB - 1));
        drain();
        write_radix(RADIX_MAX);
        send_value(VB'(35));
        send_value(VB'(36));
        send_value('1);
        send_value('0);
        drain();
        // invalid bases: zero still gives one '0' digit
        write_radix(6'd0);
        send_value('0);
        send_value(VB'(5));
        drain();
        write_radix(6'd1);
        send_value('0);
        send_value('1);
        drain();
        write_radix(6'd37);
        send_value(VB'(1));
        drain();
        write_radix(6'd63);
        send_value(VB'(32'h5555_5555));
        send_value('0);
        drain();

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: r = RADIX_MIN;
                1: r = RADIX_MAX;
                2: r = 6'd7;
                4: r = 6'd16;
                5: r = 6'd3;
                7: r = 6'd10;
                3, 9: r = RADIX_W'($urandom_range(0, 63));
                default: r = RADIX_W'($urandom_range(2, 36));
            endcase
            if (p == 4)
            begin
                tx_idle_pct = 78;
                rx_idle_pct = 28;
            end else if (p == 7)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_radix(r);
            if (p == 7)
                -> hold_kick;
            for (int i = 0; i < 37; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    v = '0;
                else if (pick < 20)
                    v = VB'($urandom_range(0, 40));
                else
                    v = VB'($urandom) >> $urandom_range(0, VB - 1);
                send_value(v);
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("tb_integer_to_radix_digits_unit: clean");
        else
            $display("tb_integer_to_radix_digits_unit: errors");
        $finish;
    end

endmodule

/* filelist.f */
src/ir2d_pkg.sv
src/ir2d_ctrl.sv
src/ir2d_dpath.sv
src/integer_to_radix_digits_unit.sv
dv/ir2d_digit_checker.sv
dv/tb_integer_to_radix_digits_unit.sv
